// File: rtl/core/ffra_pkg.sv
`timescale 1ns / 1ps

package ffra_pkg;

  localparam int unsigned EntryCount = 64;
  localparam int unsigned SlotW = $clog2(EntryCount);
  localparam int unsigned PageShift = 12;
  localparam logic [32:0] HeapBase = 33'd4096;
  localparam logic [31:0] MemReset = 32'd268435456;

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree = 2'd1;
  localparam logic [1:0] OpCheck = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoMemory = 2'd1;
  localparam logic [1:0] StBadHandle = 2'd2;
  localparam logic [1:0] StOutOfRange = 2'd3;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic next_cand;
    logic commit_alloc;
    logic do_free;
    logic lookup;
    logic finish;
    logic [1:0] status;
  } ffra_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       slot_found;
    logic       handle_ok;
    logic       fits;
    logic       scan_last;
    logic       overlap_any;
    logic       check_ok;
  } ffra_stat_t;

endpackage

// File: rtl/core/first_fit_region_allocator_unit.sv
`timescale 1ns / 1ps
// Channel   Signals                                             Direction
// in        in_valid, in_stall, op_i, request_bytes_i,            into block
//           handle_in_i, access_offset_i
// out       out_valid, out_stall, status_o, entry_handle_o,       out of block
//           region_address_o
// cfg       cfg_we, cfg_wdata                                     into block
// Free, bad handles, unknown operations and a full table finish in the decide state;
// check adds read and check states. Allocate does a fit test, a sequential scan of all
// 64 entries over one memory read port and a judge per candidate until one fits or none can.
// Reset clears all used marks at once; no clearing pass is needed.
// A result waiting under stall holds the input stalled.

module first_fit_region_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op_i,
  input  logic [31:0] request_bytes_i,
  input  logic [6:0]  handle_in_i,
  input  logic [31:0] access_offset_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status_o,
  output logic [6:0]  entry_handle_o,
  output logic [31:0] region_address_o,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import ffra_pkg::*;

  ffra_cmd_t cmd;
  ffra_stat_t stat;
  logic [31:0] mem_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mem_bytes_q <= MemReset;
    else if (cfg_we) mem_bytes_q <= cfg_wdata;
  end

  ffra_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd_o(cmd), .stat_i(stat)
  );

  ffra_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .memory_bytes_i(mem_bytes_q),
    .op_i, .request_bytes_i, .handle_in_i, .access_offset_i,
    .status_o, .entry_handle_o, .region_address_o
  );

endmodule

// File: rtl/core/ffra_datapath.sv
`timescale 1ns / 1ps

module ffra_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffra_pkg::ffra_cmd_t cmd_i,
  output ffra_pkg::ffra_stat_t stat_o,
  input  logic [31:0]         memory_bytes_i,
  input  logic [1:0]          op_i,
  input  logic [31:0]         request_bytes_i,
  input  logic [6:0]          handle_in_i,
  input  logic [31:0]         access_offset_i,
  output logic [1:0]          status_o,
  output logic [6:0]          entry_handle_o,
  output logic [31:0]         region_address_o
);
  import ffra_pkg::*;

  logic [31:0] base_mem [EntryCount];
  logic [31:0] len_mem [EntryCount];
  logic [EntryCount-1:0] used_q, used_d;

  logic [1:0] op_q;
  logic [31:0] req_q, offs_q;
  logic [32:0] need_q, cand_q, far_q;
  logic [SlotW-1:0] slot_q, idx_q;
  logic rd_valid_q;
  logic [31:0] rd_base_q, rd_len_q;
  logic [1:0] status_q;
  logic [6:0] hout_q;
  logic [31:0] addr_q;
  logic slot_found_q, handle_ok_q;

  logic [SlotW-1:0] free_slot;
  logic free_found;
  logic [32:0] need_d, cand_end, rd_end, step_a;
  logic overlap;
  logic [SlotW-1:0] hslot;
  logic hrange;
  logic [33:0] chk_sum;

  always_comb begin
    free_found = 1'b0;
    free_slot = '0;
    for (int i = EntryCount - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_slot = SlotW'(i);
      end
    end
  end

  assign need_d = ({1'b0, request_bytes_i == 32'd0 ? 32'd1 : request_bytes_i} +
                   33'd4095) & ~33'd4095;
  assign cand_end = cand_q + need_q;
  assign rd_end = {1'b0, rd_base_q} + {1'b0, rd_len_q};
  assign overlap = rd_valid_q && (cand_q < rd_end) && ({1'b0, rd_base_q} < cand_end);
  assign step_a = cand_q + 33'd4096;
  assign hrange = (handle_in_i != 7'd0) && ({25'd0, handle_in_i} <= 32'(EntryCount));
  assign hslot = SlotW'(handle_in_i - 7'd1);
  assign chk_sum = {2'b0, offs_q} + {2'b0, req_q};

  always_comb begin
    used_d = used_q;
    if (cmd_i.commit_alloc) used_d[slot_q] = 1'b1;
    if (cmd_i.do_free) used_d[slot_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      used_q <= used_d;
      rd_valid_q <= (cmd_i.scan_start || cmd_i.scan_step) ? used_q[idx_q] : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_base_q <= base_mem[idx_q];
    rd_len_q <= len_mem[idx_q];
    if (cmd_i.commit_alloc) begin
      base_mem[slot_q] <= cand_q[31:0];
      len_mem[slot_q] <= need_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      req_q <= request_bytes_i;
      offs_q <= access_offset_i;
      need_q <= need_d;
      cand_q <= HeapBase;
      far_q <= '0;
      idx_q <= (op_i == OpAlloc) ? '0 : hslot;
      slot_q <= (op_i == OpAlloc) ? free_slot : hslot;
      slot_found_q <= free_found;
      handle_ok_q <= hrange && used_q[hslot];
    end
    if (cmd_i.scan_start) begin
      idx_q <= idx_q + SlotW'(1);
      far_q <= '0;
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_q + SlotW'(1);
      if (overlap && rd_end > far_q) far_q <= rd_end;
    end
    if (cmd_i.next_cand) begin
      cand_q <= (far_q > step_a) ? far_q : step_a;
      idx_q <= '0;
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.status;
      hout_q <= (cmd_i.status == StOk && op_q == OpAlloc) ? 7'(slot_q) + 7'd1 : 7'd0;
      if (cmd_i.status == StOk && op_q == OpAlloc) addr_q <= cand_q[31:0];
      else if (cmd_i.status == StOk && op_q == OpCheck)
        addr_q <= rd_base_q + offs_q;
      else addr_q <= '0;
    end
  end

  logic scan_last_q;
  always_ff @(posedge clk_i) begin
    scan_last_q <= (cmd_i.scan_start || cmd_i.scan_step) &&
                   (idx_q == SlotW'(EntryCount - 1));
  end

  assign stat_o.op = op_q;
  assign stat_o.slot_found = slot_found_q;
  assign stat_o.handle_ok = handle_ok_q;
  assign stat_o.fits = (cand_end <= {1'b0, memory_bytes_i});
  assign stat_o.scan_last = scan_last_q;
  assign stat_o.overlap_any = (far_q != '0) || overlap;
  assign stat_o.check_ok = chk_sum <= {2'b0, rd_len_q};

  assign status_o = status_q;
  assign entry_handle_o = hout_q;
  assign region_address_o = addr_q;

endmodule

// File: rtl/core/ffra_ctrl.sv
`timescale 1ns / 1ps

module ffra_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffra_pkg::ffra_cmd_t  cmd_o,
  input  ffra_pkg::ffra_stat_t stat_i
);
  import ffra_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDecide = 3'd1;
  localparam logic [2:0] SFit = 3'd2;
  localparam logic [2:0] SScan = 3'd3;
  localparam logic [2:0] SJudge = 3'd4;
  localparam logic [2:0] SRead = 3'd5;
  localparam logic [2:0] SCheck = 3'd6;

  logic [2:0] state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_stall = (state_q != SIdle) || (out_valid_q && out_stall);
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && out_stall;
    cmd_o = '0;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d = SDecide;
        end
      end
      SDecide: begin
        unique case (stat_i.op)
          OpAlloc: begin
            if (stat_i.slot_found) state_d = SFit;
            else begin
              cmd_o.finish = 1'b1;
              cmd_o.status = StNoMemory;
              out_valid_d = 1'b1;
              state_d = SIdle;
            end
          end
          OpFree: begin
            cmd_o.finish = 1'b1;
            out_valid_d = 1'b1;
            state_d = SIdle;
            if (stat_i.handle_ok) begin
              cmd_o.do_free = 1'b1;
              cmd_o.status = StOk;
            end else cmd_o.status = StBadHandle;
          end
          OpCheck: begin
            if (stat_i.handle_ok) begin
              state_d = SRead;
            end else begin
              cmd_o.finish = 1'b1;
              cmd_o.status = StBadHandle;
              out_valid_d = 1'b1;
              state_d = SIdle;
            end
          end
          default: begin
            cmd_o.finish = 1'b1;
            cmd_o.status = StBadHandle;
            out_valid_d = 1'b1;
            state_d = SIdle;
          end
        endcase
      end
      SFit: begin
        if (stat_i.fits) begin
          cmd_o.scan_start = 1'b1;
          state_d = SScan;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.status = StNoMemory;
          out_valid_d = 1'b1;
          state_d = SIdle;
        end
      end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = SJudge;
      end
      SJudge: begin
        if (stat_i.overlap_any) begin
          cmd_o.next_cand = 1'b1;
          state_d = SFit;
        end else begin
          cmd_o.commit_alloc = 1'b1;
          cmd_o.finish = 1'b1;
          cmd_o.status = StOk;
          out_valid_d = 1'b1;
          state_d = SIdle;
        end
      end
      SRead: state_d = SCheck;
      SCheck: begin
        cmd_o.finish = 1'b1;
        cmd_o.status = stat_i.check_ok ? StOk : StOutOfRange;
        out_valid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == SDecide) else $error("accept did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q) else $error("finish without result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> in_stall) else $error("input open while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.commit_alloc && cmd_o.do_free)) else $error("table write clash");

endmodule
